FILE: rtl/assert_macros.svh
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition implies another one on the same edge.
`define ASSERT_IMPL(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

`endif

FILE: rtl/uel_pkg.sv
// ----------------------------------------------------------------------------
// uel_pkg
// Types and constants of the upper envelope of lines block.
// ----------------------------------------------------------------------------
package uel_pkg;

  localparam int SLOPE_W = 16;
  localparam int ICPT_W  = 32;
  localparam int BP_W    = 49;
  localparam int IDX_W   = 6;

  localparam int MAX_LINES_DEF     = 64;
  localparam int FRACTION_BITS_DEF = 16;

  // Minus-infinity breakpoint of the lowest hull line
  localparam logic signed [BP_W-1:0] BP_MIN = {1'b1, {(BP_W-1){1'b0}}};

  typedef struct packed {
    logic signed [SLOPE_W-1:0] slope;
    logic signed [ICPT_W-1:0]  intercept;
    logic                      final_line;
  } in_t;

  typedef struct packed {
    logic signed [BP_W-1:0] breakpoint;
    logic [IDX_W-1:0]       line_index;
    logic                   run_end;
    logic                   order_error;
  } out_t;

  typedef struct packed {
    logic signed [SLOPE_W-1:0] slope;
    logic signed [ICPT_W-1:0]  intercept;
    logic signed [BP_W-1:0]    breakpoint;
    logic [IDX_W-1:0]          line_index;
  } entry_t;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_INS  = 7'b0000010,
    S_CHK  = 7'b0000100,
    S_DIV  = 7'b0001000,
    S_FIN  = 7'b0010000,
    S_ERD  = 7'b0100000,
    S_EOUT = 7'b1000000
  } state_t;

endpackage

FILE: rtl/uel_ram.sv
// ----------------------------------------------------------------------------
// uel_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module uel_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port, then registered read that holds between reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/uel_div.sv
// ----------------------------------------------------------------------------
// uel_div
// Restoring divider, one quotient bit per cycle, floor rounding of a signed
// dividend by a positive divisor.
// ----------------------------------------------------------------------------
module uel_div
  import uel_pkg::*;
#(
  parameter int NUM_W = 49,
  parameter int DEN_W = 17
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] num,
  input  logic [DEN_W-1:0]        den,
  output logic                    busy,
  output logic                    done,
  output logic signed [BP_W-1:0]  quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic               busy_r, busy_nxt;
  logic               fix_r, fix_nxt;
  logic               done_r, done_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [NUM_W-1:0]   dvd_r, dvd_nxt;
  logic [DEN_W-1:0]   rem_r, rem_nxt;
  logic [DEN_W-1:0]   den_r, den_nxt;
  logic               neg_r, neg_nxt;
  logic signed [BP_W-1:0] quot_r, quot_nxt;

  logic [DEN_W:0]     trial;
  logic               take;
  logic signed [NUM_W:0] q_ext;
  logic signed [NUM_W:0] q_res;

  assign trial = {rem_r, dvd_r[NUM_W-1]};
  assign take  = trial >= {1'b0, den_r};
  assign q_ext = $signed({1'b0, dvd_r});
  assign q_res = neg_r ? -(q_ext + (NUM_W+1)'(rem_r != '0)) : q_ext;

  always_comb begin
    busy_nxt = busy_r;
    fix_nxt  = 1'b0;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    quot_nxt = quot_r;
    if (start) begin
      // load magnitude and sign
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      neg_nxt  = num[NUM_W-1];
      dvd_nxt  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      rem_nxt  = '0;
      den_nxt  = den;
    end else if (busy_r) begin
      // one restoring step
      rem_nxt = take ? DEN_W'(trial - {1'b0, den_r}) : DEN_W'(trial);
      dvd_nxt = {dvd_r[NUM_W-2:0], take};
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(NUM_W - 1)) begin
        busy_nxt = 1'b0;
        fix_nxt  = 1'b1;
      end
    end else if (fix_r) begin
      // apply floor correction
      quot_nxt = BP_W'(q_res);
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fix_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      fix_r  <= fix_nxt;
      done_r <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    dvd_r  <= dvd_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    neg_r  <= neg_nxt;
    quot_r <= quot_nxt;
  end

  assign busy = busy_r | fix_r;
  assign done = done_r;
  assign quot = quot_r;

endmodule

FILE: rtl/upper_envelope_of_lines.sv
// ----------------------------------------------------------------------------
// upper_envelope_of_lines
// Upper envelope of lines kept as a stack in RAM, with crossings from a
// shared bit-serial divider.
// ----------------------------------------------------------------------------
// Usage:
//   Lines enter on the in_ channel (in_valid/in_stall, payload in_data) in
//   nondecreasing slope order. in_stall is high while a line is in work
//   and while the envelope drains. For each crossing that a line computes,
//   it waits on the restoring divider, which produces one quotient bit per
//   cycle and then applies a floor correction; each entry popped after a
//   crossing costs one more crossing. A line marked final_line then drains
//   the envelope on the out_ channel, one transaction per hull entry, lowest
//   breakpoint first; the next entry is read only once the output register
//   is free, so a stalled transaction holds back the drain. run_end marks
//   the last entry. The output register holds its transaction while
//   out_stall is high. Out-of-order lines and lines past capacity are
//   dropped and set order_error for the set.
//   Reset (rst_n low, synchronous) empties the stack and clears the error;
//   the stack RAM is not cleared, since only pushed entries are read.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module upper_envelope_of_lines
  import uel_pkg::*;
#(
  parameter int MAX_LINES     = MAX_LINES_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  localparam int ADDR_W  = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int CNT_W   = $clog2(MAX_LINES + 1);
  localparam int NUM_W   = ICPT_W + 1 + FRACTION_BITS;
  localparam int DEN_W   = SLOPE_W + 1;
  localparam int ENTRY_W = $bits(entry_t);

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    depth_r, depth_nxt;
  logic [CNT_W-1:0]    seen_r, seen_nxt;
  logic [CNT_W-1:0]    k_r, k_nxt;
  logic signed [SLOPE_W-1:0] prev_r, prev_nxt;
  logic                err_r, err_nxt;
  in_t                 cur_r, cur_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  out_t                out_r, out_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic                ram_we, ram_re;
  logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
  entry_t              ram_wdata;
  logic [ENTRY_W-1:0]  ram_rdata;
  entry_t              top;

  logic                   div_start, div_busy, div_done;
  logic signed [NUM_W-1:0] div_num;
  logic [DEN_W-1:0]       div_den;
  logic signed [BP_W-1:0] div_quot;
  logic signed [ICPT_W:0] icpt_diff;
  logic signed [DEN_W-1:0] slope_diff;
  logic                   reject;
  logic                   last_out;

  assign top = entry_t'(ram_rdata);

  // Crossing operands against the top entry
  assign icpt_diff  = (ICPT_W+1)'(top.intercept) - (ICPT_W+1)'(cur_r.intercept);
  assign slope_diff = DEN_W'(cur_r.slope) - DEN_W'(top.slope);
  assign div_num    = NUM_W'(icpt_diff) <<< FRACTION_BITS;
  assign div_den    = slope_diff;

  assign reject   = (seen_r >= CNT_W'(MAX_LINES)) ||
                    ((seen_r != '0) && (in_data.slope < prev_r));
  assign last_out = (depth_r == '0) || ((k_r + CNT_W'(1)) == depth_r);

  uel_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_LINES)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  uel_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    depth_nxt     = depth_r;
    seen_nxt      = seen_r;
    k_nxt         = k_r;
    prev_nxt      = prev_r;
    err_nxt       = err_r;
    cur_nxt       = cur_r;
    idx_nxt       = idx_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r & out_stall;
    ram_we        = 1'b0;
    ram_waddr     = depth_r[ADDR_W-1:0];
    ram_wdata     = '{slope: cur_r.slope, intercept: cur_r.intercept,
                      breakpoint: BP_MIN, line_index: idx_r};
    ram_re        = 1'b0;
    ram_raddr     = k_r[ADDR_W-1:0];
    div_start     = 1'b0;
    case (state_r)
      S_IDLE: begin
        // take a line, screen its order and capacity
        if (in_valid) begin
          cur_nxt = in_data;
          if (reject) begin
            err_nxt   = 1'b1;
            state_nxt = S_FIN;
          end else begin
            idx_nxt   = IDX_W'(seen_r);
            seen_nxt  = seen_r + CNT_W'(1);
            prev_nxt  = in_data.slope;
            state_nxt = S_INS;
          end
        end
      end
      S_INS: begin
        // push onto an empty stack, or fetch the top entry
        if (depth_r == '0) begin
          ram_we    = 1'b1;
          depth_nxt = CNT_W'(1);
          state_nxt = S_FIN;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = ADDR_W'(depth_r - CNT_W'(1));
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        // equal slope: replace or drop; otherwise start the crossing
        if (top.slope == cur_r.slope) begin
          if (cur_r.intercept > top.intercept) begin
            depth_nxt = depth_r - CNT_W'(1);
            state_nxt = S_INS;
          end else begin
            state_nxt = S_FIN;
          end
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        // pop while the crossing lies below the top breakpoint, else push
        if (div_done) begin
          if ((depth_r >= CNT_W'(2)) && (div_quot < top.breakpoint)) begin
            depth_nxt = depth_r - CNT_W'(1);
            state_nxt = S_INS;
          end else begin
            ram_we               = 1'b1;
            ram_wdata.breakpoint = div_quot;
            depth_nxt            = depth_r + CNT_W'(1);
            state_nxt            = S_FIN;
          end
        end
      end
      S_FIN: begin
        k_nxt     = '0;
        state_nxt = cur_r.final_line ? S_ERD : S_IDLE;
      end
      S_ERD: begin
        // wait for a free output register, then read the next entry
        if (!out_valid_r) begin
          ram_re    = (depth_r != '0);
          state_nxt = S_EOUT;
        end
      end
      S_EOUT: begin
        // present one envelope transaction
        out_valid_nxt       = 1'b1;
        out_nxt.breakpoint  = (depth_r == '0) ? BP_MIN : top.breakpoint;
        out_nxt.line_index  = (depth_r == '0) ? '0 : top.line_index;
        out_nxt.run_end     = last_out;
        out_nxt.order_error = err_r;
        if (last_out) begin
          depth_nxt = '0;
          seen_nxt  = '0;
          prev_nxt  = '0;
          err_nxt   = 1'b0;
          state_nxt = S_IDLE;
        end else begin
          k_nxt     = k_r + CNT_W'(1);
          state_nxt = S_ERD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      depth_r     <= '0;
      seen_r      <= '0;
      prev_r      <= '0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      depth_r     <= depth_nxt;
      seen_r      <= seen_nxt;
      prev_r      <= prev_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
    k_r   <= k_nxt;
    cur_r <= cur_nxt;
    idx_r <= idx_nxt;
    out_r <= out_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Checks
  `ASSERT_CLK(a_depth_cap, depth_r <= CNT_W'(MAX_LINES), "stack depth over capacity")
  `ASSERT_IMPL(a_div_idle, div_start, !div_busy, "divider started while busy")
  `ASSERT_CLK(a_out_src, $rose(out_valid_r) |-> $past(state_r == S_EOUT),
              "output raised outside the drain")
  `ASSERT_IMPL(a_depth_seen, state_r == S_IDLE, depth_r <= seen_r,
               "stack deeper than lines taken")

endmodule
